// ===== design/hswd_pkg.sv =====
// ----------------------------------------------------------------------------
// Hand swipe detector package
// Shared constants, controller state type and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hswd_pkg;

    localparam int MAX_HANDS_DEF = 8;

    // Field widths of the input and result words.
    localparam int ID_W    = 32;
    localparam int COORD_W = 24;
    localparam int TS_W    = 48;
    localparam int RATIO_W = 32;
    localparam int THR_W   = 31;
    localparam int LIM_W   = 32;
    localparam int GEST_W  = 2;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // Stream word widths.
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 4;

    // Divider: (x * 65536) / y on magnitudes, one quotient bit per cycle.
    localparam int NUM_W     = COORD_W + 16;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(800000);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THRESHOLD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GESTURE_TIME_LIMIT = 1'b1;

    // Gesture codes.
    localparam logic [GEST_W-1:0] GEST_NONE  = 2'd0;
    localparam logic [GEST_W-1:0] GEST_LEFT  = 2'd1;
    localparam logic [GEST_W-1:0] GEST_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic scan_busy;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== design/hswd_divider.sv =====
// ----------------------------------------------------------------------------
// Palm ratio divider
// Restoring divider for (palm_x * 65536) / palm_y, truncated toward zero and
// saturated to the signed 32-bit range, with the zero height cases.
// ----------------------------------------------------------------------------
`default_nettype none

module hswd_divider (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [hswd_pkg::COORD_W-1:0]    x,
    input  wire logic [hswd_pkg::COORD_W-1:0]    y,
    output logic                                 busy,
    output logic [hswd_pkg::RATIO_W-1:0]         ratio
);
    import hswd_pkg::*;

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]   den_reg;
    logic                 neg_reg, yzero_reg, xneg_reg, xzero_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    logic [COORD_W-1:0]   x_mag, y_mag;
    logic [COORD_W:0]     trial;
    logic [COORD_W:0]     trial_sub;

    assign x_mag = x[COORD_W-1] ? (~x + COORD_W'(1)) : x;
    assign y_mag = y[COORD_W-1] ? (~y + COORD_W'(1)) : y;

    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb begin
        if (!trial_sub[COORD_W]) begin
            rem_next = trial_sub[COORD_W-1:0];
            num_next = {num_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = trial[COORD_W-1:0];
            num_next = {num_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg   <= {x_mag, 16'd0};
            rem_reg   <= '0;
            den_reg   <= y_mag;
            neg_reg   <= x[COORD_W-1] ^ y[COORD_W-1];
            yzero_reg <= (y == '0);
            xneg_reg  <= x[COORD_W-1];
            xzero_reg <= (x == '0);
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    // Once the count has run out the shift register holds the quotient magnitude.
    always_comb begin
        if (yzero_reg) begin
            if (xzero_reg) begin
                ratio = '0;
            end else if (xneg_reg) begin
                ratio = 32'h8000_0000;
            end else begin
                ratio = 32'h7FFF_FFFF;
            end
        end else if (neg_reg) begin
            if (num_reg > NUM_W'(40'h00_8000_0000)) begin
                ratio = 32'h8000_0000;
            end else begin
                ratio = ~num_reg[RATIO_W-1:0] + RATIO_W'(1);
            end
        end else begin
            if (num_reg > NUM_W'(40'h00_7FFF_FFFF)) begin
                ratio = 32'h7FFF_FFFF;
            end else begin
                ratio = num_reg[RATIO_W-1:0];
            end
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ===== design/hswd_datapath.sv =====
// ----------------------------------------------------------------------------
// Hand swipe detector datapath
// Input capture, hand table with its sequential search, swipe and hold time
// decision, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hswd_datapath #(
    parameter int MAX_HANDS = hswd_pkg::MAX_HANDS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire hswd_pkg::ctrl_cmd_t               cmd,
    output hswd_pkg::ctrl_sts_t                    sts,
    input  wire logic [hswd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [hswd_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [hswd_pkg::M_TUSER_W-1:0]         m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [hswd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hswd_pkg::CFG_W-1:0]        cfg_data
);
    import hswd_pkg::*;

    localparam int IDX_W = (MAX_HANDS > 1) ? $clog2(MAX_HANDS) : 1;

    // Captured input word.
    logic [ID_W-1:0]    id_reg;
    logic [TS_W-1:0]    ts_reg;
    logic               present_reg, last_reg;

    // Configuration.
    logic [THR_W-1:0] thr_reg;
    logic [LIM_W-1:0] lim_reg;

    // Hand table.
    logic [MAX_HANDS-1:0] valid_reg, valid_next;
    logic [MAX_HANDS-1:0] seen_reg, seen_next;
    logic [ID_W-1:0]      entry_id_reg  [MAX_HANDS];
    logic [RATIO_W-1:0]   entry_ref_reg [MAX_HANDS];

    // Hold timer.
    logic [TS_W-1:0] last_time_reg;
    logic            armed_reg;

    // Search.
    logic             scan_busy_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic             found_reg, free_found_reg;
    logic [IDX_W-1:0] slot_reg, free_slot_reg;

    // Decision.
    logic signed [RATIO_W:0] diff_reg;
    logic                    hold_lt_reg;
    logic [TS_W-1:0]         elapsed;

    // Result register.
    logic                 m_valid_reg;
    logic [GEST_W-1:0]    gest_reg;
    logic [ID_W-1:0]      id_out_reg;
    logic                 new_reg, full_reg;

    logic                 div_busy;
    logic [RATIO_W-1:0]   ratio;

    logic signed [RATIO_W+1:0] diff_ext, thr_ext, sum_left, sum_right;
    logic                      left_hit, right_hit, swipe;

    hswd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load && s_tuser),
        .x       (s_tdata[55:32]),
        .y       (s_tdata[79:56]),
        .busy    (div_busy),
        .ratio   (ratio)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg      <= s_tdata[31:0];
            ts_reg      <= s_tdata[127:80];
            present_reg <= s_tuser;
            last_reg    <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            lim_reg <= LIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ANGLE_THRESHOLD:    thr_reg <= cfg_data[THR_W-1:0];
                REG_GESTURE_TIME_LIMIT: lim_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The search walks the table one entry a cycle while the divider runs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_busy_reg <= 1'b0;
        end else if (cmd.load) begin
            scan_busy_reg <= s_tuser;
        end else if (scan_busy_reg && scan_idx_reg == IDX_W'(MAX_HANDS - 1)) begin
            scan_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (scan_busy_reg) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (valid_reg[scan_idx_reg]) begin
                if (!found_reg && entry_id_reg[scan_idx_reg] == id_reg) begin
                    found_reg <= 1'b1;
                    slot_reg  <= scan_idx_reg;
                end
            end else if (!free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= scan_idx_reg;
            end
        end
    end

    // Before the timer is armed the elapsed time counts as zero.
    assign elapsed = ts_reg - last_time_reg;

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            diff_reg    <= $signed({ratio[RATIO_W-1], ratio})
                         - $signed({entry_ref_reg[slot_reg][RATIO_W-1],
                                    entry_ref_reg[slot_reg]});
            hold_lt_reg <= armed_reg ? (elapsed < {{(TS_W-LIM_W){1'b0}}, lim_reg})
                                     : (lim_reg != '0);
        end
    end

    assign diff_ext  = {diff_reg[RATIO_W], diff_reg};
    assign thr_ext   = {3'b000, thr_reg};
    assign sum_left  = diff_ext + thr_ext;
    assign sum_right = thr_ext - diff_ext;
    assign left_hit  = sum_left[RATIO_W+1];
    assign right_hit = sum_right[RATIO_W+1];
    assign swipe     = present_reg && found_reg && (left_hit || right_hit);

    always_comb begin
        valid_next = valid_reg;
        seen_next  = seen_reg;
        if (present_reg) begin
            if (found_reg) begin
                seen_next[slot_reg] = 1'b1;
            end else if (free_found_reg) begin
                valid_next[free_slot_reg] = 1'b1;
                seen_next[free_slot_reg]  = 1'b1;
            end
        end
        // At the end of a frame, hands not seen in it leave the table.
        if (last_reg) begin
            valid_next = valid_next & seen_next;
            seen_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            seen_reg      <= '0;
            armed_reg     <= 1'b0;
            last_time_reg <= '0;
        end else if (cmd.commit) begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
            if (swipe) begin
                armed_reg <= 1'b1;
                if (!armed_reg || !hold_lt_reg) begin
                    last_time_reg <= ts_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && present_reg) begin
            if (found_reg) begin
                if (swipe) begin
                    entry_ref_reg[slot_reg] <= ratio;
                end
            end else if (free_found_reg) begin
                entry_id_reg[free_slot_reg]  <= id_reg;
                entry_ref_reg[free_slot_reg] <= ratio;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            id_out_reg <= present_reg ? id_reg : '0;
            new_reg    <= present_reg && !found_reg && free_found_reg;
            full_reg   <= present_reg && !found_reg && !free_found_reg;
            if (swipe && !hold_lt_reg) begin
                gest_reg <= left_hit ? GEST_LEFT : GEST_RIGHT;
            end else begin
                gest_reg <= GEST_NONE;
            end
        end
    end

    assign sts.div_busy  = div_busy;
    assign sts.scan_busy = scan_busy_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = id_out_reg;
    assign m_tuser  = {full_reg, new_reg, gest_reg};

endmodule

`default_nettype wire

// ===== design/hswd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hand swipe detector controller
// Sequences capture, ratio and search, decision and commit of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module hswd_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire hswd_pkg::ctrl_sts_t   sts,
    output hswd_pkg::ctrl_cmd_t        cmd
);
    import hswd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!sts.div_busy && !sts.scan_busy) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // The result register must be free, or emptied in this cycle.
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/hand_swipe_gesture_detector_core.sv =====
// ----------------------------------------------------------------------------
// Hand swipe gesture detector
// Tracks hand ids across frames and reports left and right swipes from the
// change of the palm ratio x / y, under a global hold time.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_*      in         tracked hand word, frame end on s_tlast
//  m_*      out        one result word for each input word
//  cfg_*    in         register writes, no read-back
//
//  A hand word goes from acceptance through the divider, one quotient bit per
//  cycle, and the decide and commit steps to the result register; the table
//  search runs beside it. An empty frame marker skips divider and search.
//  Reset clears the table valid bits, the hold timer and the result valid.
//  A result waiting on m_tready holds the commit step but not acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module hand_swipe_gesture_detector_core #(
    parameter int MAX_HANDS = hswd_pkg::MAX_HANDS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // hand_id[31:0], palm_x[55:32], palm_y[79:56], timestamp[127:80]
    input  wire logic [hswd_pkg::S_TDATA_W-1:0]    s_tdata,
    // hand_present[0]
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hand_id_out[31:0]
    output logic [hswd_pkg::M_TDATA_W-1:0]         m_tdata,
    // gesture[1:0], new_hand[2], table_full[3]
    output logic [hswd_pkg::M_TUSER_W-1:0]         m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [hswd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hswd_pkg::CFG_W-1:0]        cfg_data
);
    import hswd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    hswd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hswd_datapath #(
        .MAX_HANDS (MAX_HANDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== design/hswd_checker.sv =====
// ----------------------------------------------------------------------------
// Hand swipe detector port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module hswd_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [hswd_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [hswd_pkg::M_TUSER_W-1:0]    m_tuser
);
    import hswd_pkg::*;

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One word is worked on at a time, so acceptance drops ready.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while a word is in progress");

    // A gesture, a new hand and a full table exclude one another.
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] != 2'd3)
                     && !(m_tuser[2] && m_tuser[3])
                     && ((m_tuser[1:0] == GEST_NONE) || (!m_tuser[2] && !m_tuser[3])))
        else $error("inconsistent result flags");

    // Reset empties the result register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind hand_swipe_gesture_detector_core hswd_checker u_hswd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
